// ===== sv/gda_pkg.sv =====
// package for the gregorian date adder: widths, constants, beat types and state codes
`timescale 1ns / 1ps

package gda_pkg;

    localparam int ADD_DAYS_BITS_DEF = 16;
    localparam int ADD_W             = 16;
    localparam int DAY_W             = 25;
    localparam int YEAR_W            = 14;
    localparam int MONTH_W           = 4;
    localparam int MDAY_W            = 5;
    localparam int DOY_W             = 9;
    localparam int YMOD_W            = 9;

    localparam logic [YEAR_W-1:0]  MAX_YEAR   = 14'd9999;
    localparam logic [YEAR_W-1:0]  YEAR_SPAN  = 14'd400;
    localparam logic [YMOD_W-1:0]  YMOD_LAST  = 9'd399;
    localparam logic [YMOD_W-1:0]  CENT_1     = 9'd100;
    localparam logic [YMOD_W-1:0]  CENT_2     = 9'd200;
    localparam logic [YMOD_W-1:0]  CENT_3     = 9'd300;
    localparam logic [DAY_W-1:0]   DAYS_400   = 25'd146097;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR  = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN  = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP  = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV  = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [MDAY_W-1:0]  LEN_LEAP   = 5'd29;
    localparam logic [MDAY_W-1:0]  LEN_FEB    = 5'd28;
    localparam logic [MDAY_W-1:0]  LEN_SHORT  = 5'd30;
    localparam logic [MDAY_W-1:0]  LEN_LONG   = 5'd31;
    localparam logic [DOY_W-1:0]   SAT_DOY    = 9'd365;

    typedef struct packed {
        logic [MDAY_W-1:0]  in_day;
        logic [MONTH_W-1:0] in_month;
        logic [YEAR_W-1:0]  in_year;
        logic [ADD_W-1:0]   add_days;
        logic [MDAY_W-1:0]  other_day;
        logic [MONTH_W-1:0] other_month;
        logic [YEAR_W-1:0]  other_year;
    } gda_cmd_t;

    typedef struct packed {
        logic [MDAY_W-1:0]  out_day;
        logic [MONTH_W-1:0] out_month;
        logic [YEAR_W-1:0]  out_year;
        logic [DOY_W-1:0]   day_of_year;
        logic               is_earlier;
        logic               year_overflow;
    } gda_res_t;

    typedef struct packed {
        logic [DAY_W-1:0] a;
        logic [DAY_W-1:0] b;
        logic             sub;
    } alu_in_t;

    typedef struct packed {
        logic [DAY_W-1:0] sum;
        logic             carry;
    } alu_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_RUN,
        ST_DOY
    } state_t;

endpackage

// ===== sv/gregorian_date_adder.sv =====
// top level of the gregorian date adder: sequencer and datapath registers
//
//  channel  | ports                 | handshake
//  ---------+-----------------------+-------------------------------------
//  command  | cmd (gda_cmd_t)       | beat taken at start && !busy
//  result   | result (gda_res_t)    | one-cycle beat marked by done
//
// sequence: the load, then reducing the year mod 400, then stepping by 400-year
// jumps or by months until a step finds the result month, then summing the
// lengths of the months before the result month for the day of year; the
// single add/subtract unit sets every step
// reset clears the sequencer and the done strobe; busy is low after reset
// the result cannot be stalled; the next command beat may come in the cycle done is high
`timescale 1ns / 1ps

module gregorian_date_adder #(
    parameter int ADD_DAYS_BITS = gda_pkg::ADD_DAYS_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  gda_pkg::gda_cmd_t cmd,
    output logic              done,
    output gda_pkg::gda_res_t result
);
    import gda_pkg::*;

    localparam int NB = (ADD_DAYS_BITS > ADD_W) ? ADD_W : ADD_DAYS_BITS;
    localparam logic [ADD_W-1:0] N_MASK = ADD_W'((17'(1) << NB) - 17'(1));

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    logic [DAY_W-1:0]   d_reg, d_next;
    logic [MONTH_W-1:0] m_reg, m_next;
    logic [YEAR_W-1:0]  y_reg, y_next;
    logic [YEAR_W-1:0]  ymod_reg, ymod_next;
    logic [DOY_W-1:0]   doy_reg, doy_next;
    logic [MONTH_W-1:0] k_reg, k_next;
    logic               ovf_reg, ovf_next;
    logic               early_reg, early_next;
    gda_res_t           res_reg, res_next;

    alu_in_t            alu_op;
    alu_out_t           alu_res;
    logic [MONTH_W-1:0] cal_month;
    logic [MDAY_W-1:0]  cal_len;

    logic               emit;
    logic               emit_ovf;
    logic [DOY_W-1:0]   emit_doy;
    logic               skip;
    logic               gt;
    logic [YEAR_W-1:0]  y_inc;
    logic [MDAY_W-1:0]  d_fix;
    logic [MONTH_W-1:0] m_fix;

    gda_alu u_alu (
        .op  (alu_op),
        .res (alu_res)
    );

    gda_cal u_cal (
        .month (cal_month),
        .ymod  (ymod_reg[YMOD_W-1:0]),
        .len   (cal_len)
    );

    assign skip  = (m_reg == MONTH_JAN) && (d_reg > DAYS_400);
    assign gt    = skip || (alu_res.carry && (alu_res.sum != '0));
    assign y_inc = y_reg + (skip ? YEAR_SPAN : YEAR_W'(1));
    assign d_fix = (cmd.in_day == '0) ? MDAY_W'(1) : cmd.in_day;

    always_comb
    begin
        if (cmd.in_month == '0)
            m_fix = MONTH_JAN;
        else if (cmd.in_month > MONTH_DEC)
            m_fix = MONTH_DEC;
        else
            m_fix = cmd.in_month;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        m_reg     <= m_next;
        y_reg     <= y_next;
        ymod_reg  <= ymod_next;
        doy_reg   <= doy_next;
        k_reg     <= k_next;
        ovf_reg   <= ovf_next;
        early_reg <= early_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        d_next     = d_reg;
        m_next     = m_reg;
        y_next     = y_reg;
        ymod_next  = ymod_reg;
        doy_next   = doy_reg;
        k_next     = k_reg;
        ovf_next   = ovf_reg;
        early_next = early_reg;
        emit       = 1'b0;
        emit_ovf   = 1'b0;
        emit_doy   = d_reg[DOY_W-1:0];
        cal_month  = m_reg;
        alu_op.a   = d_reg;
        alu_op.b   = DAY_W'(cal_len);
        alu_op.sub = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                alu_op.a   = DAY_W'(d_fix);
                alu_op.b   = DAY_W'(cmd.add_days & N_MASK);
                alu_op.sub = 1'b0;
                if (start)
                begin
                    d_next     = alu_res.sum;
                    m_next     = m_fix;
                    y_next     = cmd.in_year;
                    ymod_next  = cmd.in_year;
                    ovf_next   = cmd.in_year > MAX_YEAR;
                    early_next = (cmd.in_year < cmd.other_year)
                                 || ((cmd.in_year == cmd.other_year)
                                     && (cmd.in_month < cmd.other_month))
                                 || ((cmd.in_year == cmd.other_year)
                                     && (cmd.in_month == cmd.other_month)
                                     && (cmd.in_day < cmd.other_day));
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                alu_op.a = DAY_W'(ymod_reg);
                alu_op.b = DAY_W'(YEAR_SPAN);
                if (ovf_reg)
                begin
                    emit       = 1'b1;
                    emit_ovf   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (alu_res.carry)
                    ymod_next = alu_res.sum[YEAR_W-1:0];
                else
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                alu_op.b = skip ? DAYS_400 : DAY_W'(cal_len);
                if (!gt)
                begin
                    doy_next = d_reg[DOY_W-1:0];
                    k_next   = MONTH_JAN;
                    if (m_reg == MONTH_JAN)
                    begin
                        emit       = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                        state_next = ST_DOY;
                end
                else
                begin
                    d_next = alu_res.sum;
                    if (skip || (m_reg == MONTH_DEC))
                    begin
                        y_next = y_inc;
                        if (!skip)
                        begin
                            m_next    = MONTH_JAN;
                            ymod_next = (ymod_reg[YMOD_W-1:0] == YMOD_LAST) ? '0
                                        : ymod_reg + YEAR_W'(1);
                        end
                        if (y_inc > MAX_YEAR)
                        begin
                            emit       = 1'b1;
                            emit_ovf   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                        m_next = m_reg + MONTH_W'(1);
                end
            end
            ST_DOY:
            begin
                cal_month  = k_reg;
                alu_op.a   = DAY_W'(doy_reg);
                alu_op.sub = 1'b0;
                doy_next   = alu_res.sum[DOY_W-1:0];
                k_next     = k_reg + MONTH_W'(1);
                emit_doy   = alu_res.sum[DOY_W-1:0];
                if (k_next == m_reg)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        done_next = emit;
        res_next  = res_reg;
        if (emit)
        begin
            res_next.is_earlier    = early_reg;
            res_next.year_overflow = emit_ovf;
            if (emit_ovf)
            begin
                res_next.out_day     = LEN_LONG;
                res_next.out_month   = MONTH_DEC;
                res_next.out_year    = MAX_YEAR;
                res_next.day_of_year = SAT_DOY;
            end
            else
            begin
                res_next.out_day     = d_reg[MDAY_W-1:0];
                res_next.out_month   = m_reg;
                res_next.out_year    = y_reg;
                res_next.day_of_year = emit_doy;
            end
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command beat did not start the sequencer");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.year_overflow) |->
            (result.out_year == MAX_YEAR) && (result.out_month == MONTH_DEC))
        else $error("overflow result not saturated");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.out_month >= MONTH_JAN) && (result.out_month <= MONTH_DEC)
                 && (result.out_day != '0))
        else $error("result date out of range");
`endif

endmodule

// ===== sv/gda_alu.sv =====
// shared add/subtract unit of the date adder
`timescale 1ns / 1ps

module gda_alu (
    input  gda_pkg::alu_in_t  op,
    output gda_pkg::alu_out_t res
);
    import gda_pkg::*;

    logic [DAY_W:0] ext;

    // carry out of a subtract means a >= b
    assign ext = {1'b0, op.a} + {1'b0, (op.sub ? ~op.b : op.b)} + (DAY_W + 1)'(op.sub);
    assign res.sum   = ext[DAY_W-1:0];
    assign res.carry = ext[DAY_W];

endmodule

// ===== sv/gda_cal.sv =====
// month length lookup with the gregorian leap rule
`timescale 1ns / 1ps

module gda_cal (
    input  logic [gda_pkg::MONTH_W-1:0] month,
    input  logic [gda_pkg::YMOD_W-1:0]  ymod,
    output logic [gda_pkg::MDAY_W-1:0]  len
);
    import gda_pkg::*;

    logic leap;

    // ymod is the year modulo 400
    assign leap = (ymod[1:0] == 2'b00) && (ymod != CENT_1) && (ymod != CENT_2)
                  && (ymod != CENT_3);

    always_comb
    begin
        case (month)
            MONTH_FEB: len = leap ? LEN_LEAP : LEN_FEB;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
            default: len = LEN_LONG;
        endcase
    end

endmodule
